>>> rtl/qualified_provider_table_defines.svh
// assertion macros for the qualified provider table
`ifndef QUALIFIED_PROVIDER_TABLE_DEFINES_SVH
`define QUALIFIED_PROVIDER_TABLE_DEFINES_SVH
// implication checked every cycle outside reset
`define QPT_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);
// next-cycle implication
`define QPT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);
`endif

>>> rtl/qpt_pkg.sv
// ---------------------------------------------------------------------------
// qpt_pkg
// types and constants shared by the provider table modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package qpt_pkg;
  localparam int SLOTS_DEF = 16;
  localparam logic [16:0] ONE_Q15 = 17'd32768;
  localparam logic [15:0] CNT_MAX = 16'hffff;
  localparam logic [16:0] MIN_OUTCOMES = 17'd4;

  typedef enum logic [2:0] {
    OP_REGISTER = 3'd0,
    OP_BAN      = 3'd1,
    OP_UNBAN    = 3'd2,
    OP_SELECT   = 3'd3,
    OP_REPORT   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RISK      = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_NONE      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_WEIGHT = 2'd0,
    CFG_FLOOR  = 2'd1,
    CFG_SLOTS  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] provider_key;
    logic [31:0] price;
    logic [15:0] risk;
    logic signed [23:0] latency;
    logic        accepted;
    logic        success;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic [31:0] chosen_key;
    logic [31:0] chosen_price;
    logic [15:0] chosen_risk;
    logic [22:0] chosen_latency;
    logic        auto_banned;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic scan_start; // reset scan pointer and best
    logic scan_step;  // examine one slot
    logic wr_new;     // append new entry
    logic wr_flags;   // ban or unban found entry
    logic rpt_calc;   // report arithmetic stage
    logic rpt_write;  // report write back
    logic res_load;   // build result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic full;
    logic risk_bad;
  } sts_t;
endpackage
`default_nettype wire

>>> rtl/qpt_if.sv
// ---------------------------------------------------------------------------
// qpt_stream_if
// valid/ready channel carrying one item
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface qpt_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/qpt_ctrl.sv
// ---------------------------------------------------------------------------
// qpt_ctrl
// sequencer for table operations
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "qualified_provider_table_defines.svh"
module qpt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    in_op,
  output logic               out_valid,
  input  wire logic          out_ready,
  output qpt_pkg::cmd_t      cmd,
  input  wire qpt_pkg::sts_t sts
);
  import qpt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_CALC  = 6'b000100,
    S_WRITE = 6'b001000,
    S_RES   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] op_r, op_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          op_nxt         = in_op;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_RES;
          case (op_r)
            OP_REGISTER: if (!sts.risk_bad && !sts.full && !sts.hit) state_nxt = S_WRITE;
            OP_BAN, OP_UNBAN: if (sts.hit) state_nxt = S_WRITE;
            OP_REPORT: if (sts.hit) state_nxt = S_CALC;
            default: state_nxt = S_RES;
          endcase
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_CALC: begin
        cmd.rpt_calc = 1'b1;
        state_nxt    = S_WRITE;
      end
      S_WRITE: begin
        case (op_r)
          OP_REGISTER: cmd.wr_new = 1'b1;
          OP_REPORT:   cmd.rpt_write = 1'b1;
          default:     cmd.wr_flags = 1'b1;
        endcase
        state_nxt = S_RES;
      end
      S_RES: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= 3'd0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  `QPT_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")
  `QPT_ASSERT_IMP(a_calc_rpt, clk, rst_n, state_r == S_CALC, op_r == OP_REPORT,
    "calc without report")
  `QPT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
    "result dropped")
endmodule
`default_nettype wire

>>> rtl/qpt_dpath.sv
// ---------------------------------------------------------------------------
// qpt_dpath
// provider table storage, slot scan and report arithmetic
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qpt_dpath #(
  parameter int SLOTS = qpt_pkg::SLOTS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire qpt_pkg::item_t  item,
  input  wire qpt_pkg::cmd_t   cmd,
  output qpt_pkg::sts_t        sts,
  output qpt_pkg::result_t     res,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [15:0]     cfg_data
);
  import qpt_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic [15:0] weight_r, floor_r;
  logic [4:0]  slots_r;

  logic [31:0] key_m   [SLOTS];
  logic [31:0] price_m [SLOTS];
  logic [15:0] risk_m  [SLOTS];
  logic [22:0] lat_m   [SLOTS];
  logic        acc_m   [SLOTS];
  logic        ban_m   [SLOTS];
  logic [15:0] succ_m  [SLOTS];
  logic [15:0] fail_m  [SLOTS];

  logic [CW-1:0] count_r;
  item_t         it_r;
  logic [CW-1:0] ptr_r;
  logic          hit_r, found_r;
  logic [IW-1:0] idx_r;
  logic          abn_r;
  logic          wrote_r;
  logic [15:0]   nrisk_r;
  logic [22:0]   nlat_r;
  logic [15:0]   nsucc_r, nfail_r;

  logic [CW-1:0] cap;
  logic [IW-1:0] p;
  logic          scan_end;
  logic          qual, better;
  result_t       res_nxt;

  always_comb begin
    if ({27'd0, slots_r} > 32'(SLOTS)) cap = CW'(SLOTS);
    else cap = CW'(slots_r);
  end

  assign p        = ptr_r[IW-1:0];
  assign scan_end = (ptr_r >= count_r) || (it_r.operation != OP_SELECT && hit_r);

  assign qual = acc_m[p] && !ban_m[p] && price_m[p] <= it_r.price && risk_m[p] <= it_r.risk
             && !it_r.latency[23] && {1'b0, lat_m[p]} <= it_r.latency;
  assign better = !found_r || price_m[p] < price_m[idx_r]
               || (price_m[p] == price_m[idx_r] && (risk_m[p] < risk_m[idx_r]
               || (risk_m[p] == risk_m[idx_r] && lat_m[p] < lat_m[idx_r])));

  assign sts.scan_done = scan_end;
  assign sts.hit       = hit_r;
  assign sts.full      = (count_r >= cap);
  assign sts.risk_bad  = ({1'b0, it_r.risk} > ONE_Q15);

  // report arithmetic
  logic [16:0] a, obs, oma;
  logic [33:0] rsum;
  logic [40:0] lsum;
  logic [18:0] rnew;
  logic [25:0] lnew;
  logic [15:0] s1, f1;
  logic [16:0] tot;
  logic [15:0] rclip;

  always_comb begin
    a    = ({1'b0, weight_r} > ONE_Q15) ? ONE_Q15 : {1'b0, weight_r};
    oma  = ONE_Q15 - a;
    obs  = ({1'b0, it_r.risk} > ONE_Q15) ? ONE_Q15 : {1'b0, it_r.risk};
    rsum = ({17'd0, a} * {18'd0, risk_m[idx_r]}) + ({17'd0, oma} * {17'd0, obs})
         + 34'd16384;
    rnew = rsum[33:15];
    rclip = (rnew > 19'(ONE_Q15)) ? ONE_Q15[15:0] : rnew[15:0];
    lsum = ({24'd0, a} * {18'd0, lat_m[idx_r]})
         + ({24'd0, oma} * {18'd0, it_r.latency[22:0]}) + 41'd16384;
    lnew = lsum[40:15];
    s1 = succ_m[idx_r];
    f1 = fail_m[idx_r];
    if (it_r.success) begin
      if (s1 != CNT_MAX) s1 = s1 + 16'd1;
    end else begin
      if (f1 != CNT_MAX) f1 = f1 + 16'd1;
    end
    tot = {1'b0, s1} + {1'b0, f1};
  end

  // result of the finished operation
  always_comb begin
    res_nxt = '0;
    case (it_r.operation)
      OP_REGISTER: begin
        if (sts.risk_bad) res_nxt.status = ST_RISK;
        else if (wrote_r) res_nxt.slot_index = 4'(count_r - CW'(1));
        else if (sts.full) res_nxt.status = ST_FULL;
        else begin
          res_nxt.status     = ST_DUPLICATE;
          res_nxt.slot_index = 4'(idx_r);
        end
      end
      OP_BAN, OP_UNBAN, OP_REPORT: begin
        if (!hit_r) res_nxt.status = ST_NOT_FOUND;
        else begin
          res_nxt.slot_index  = 4'(idx_r);
          res_nxt.auto_banned = (it_r.operation == OP_REPORT) && abn_r;
        end
      end
      OP_SELECT: begin
        if (!found_r) res_nxt.status = ST_NONE;
        else begin
          res_nxt.slot_index     = 4'(idx_r);
          res_nxt.chosen_key     = key_m[idx_r];
          res_nxt.chosen_price   = price_m[idx_r];
          res_nxt.chosen_risk    = risk_m[idx_r];
          res_nxt.chosen_latency = lat_m[idx_r];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= 16'd26214;
      floor_r  <= 16'd22938;
      slots_r  <= 5'd16;
      count_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WEIGHT: weight_r <= cfg_data;
          CFG_FLOOR:  floor_r  <= cfg_data;
          CFG_SLOTS:  slots_r  <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (cmd.wr_new) count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) it_r <= item;
    if (cmd.scan_start) begin
      ptr_r   <= '0;
      hit_r   <= 1'b0;
      found_r <= 1'b0;
      idx_r   <= '0;
      abn_r   <= 1'b0;
      wrote_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      ptr_r <= ptr_r + CW'(1);
      if (it_r.operation == OP_SELECT) begin
        if (qual && better) begin
          found_r <= 1'b1;
          idx_r   <= p;
        end
      end else if (key_m[p] == it_r.provider_key) begin
        hit_r <= 1'b1;
        idx_r <= p;
      end
    end
    if (cmd.rpt_calc) begin
      nrisk_r <= rclip;
      nlat_r  <= it_r.latency[23] ? lat_m[idx_r] : lnew[22:0];
      nsucc_r <= s1;
      nfail_r <= f1;
      abn_r   <= !ban_m[idx_r] && tot >= MIN_OUTCOMES && rclip >= floor_r && f1 > s1;
    end
    if (cmd.rpt_write) begin
      risk_m[idx_r] <= abn_r ? ONE_Q15[15:0] : nrisk_r;
      lat_m[idx_r]  <= nlat_r;
      succ_m[idx_r] <= nsucc_r;
      fail_m[idx_r] <= nfail_r;
      if (abn_r) ban_m[idx_r] <= 1'b1;
    end
    if (cmd.wr_flags) begin
      if (it_r.operation == OP_BAN) begin
        ban_m[idx_r]  <= 1'b1;
        risk_m[idx_r] <= ONE_Q15[15:0];
      end else begin
        ban_m[idx_r] <= 1'b0;
      end
    end
    if (cmd.wr_new) begin
      wrote_r                  <= 1'b1;
      key_m[count_r[IW-1:0]]   <= it_r.provider_key;
      price_m[count_r[IW-1:0]] <= it_r.price;
      risk_m[count_r[IW-1:0]]  <= it_r.risk;
      lat_m[count_r[IW-1:0]]   <= it_r.latency[23] ? 23'd0 : it_r.latency[22:0];
      acc_m[count_r[IW-1:0]]   <= it_r.accepted;
      ban_m[count_r[IW-1:0]]   <= 1'b0;
      succ_m[count_r[IW-1:0]]  <= '0;
      fail_m[count_r[IW-1:0]]  <= '0;
    end
    if (cmd.res_load) res <= res_nxt;
  end
endmodule
`default_nettype wire

>>> rtl/qualified_provider_table.sv
// ---------------------------------------------------------------------------
// qualified_provider_table
// provider table with register, ban, unban, report and select
// ---------------------------------------------------------------------------
// in_*: one valid/ready item per operation; out_*: one result item per input.
// cfg_*: write enable, index and data; write only while the block is idle.
// an item is taken only in idle; the slot scan walks the table one slot a
// cycle and stops early on a key match for every operation but select.
// report adds an arithmetic stage ahead of its write-back.
// the result sits in an output register until taken; while the receiver
// stalls no new item is accepted.
// reset clears the entry count and the configuration to defaults; the
// table itself needs no clearing since only filled slots are read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qualified_provider_table #(
  parameter int SLOTS = qpt_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  qpt_stream_if.sink       in_ch,
  qpt_stream_if.source     out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import qpt_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  result_t res;

  qpt_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.payload.operation),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  qpt_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk, .rst_n, .item(in_ch.payload), .cmd, .sts, .res,
    .cfg_we, .cfg_index, .cfg_data
  );

  assign out_ch.payload = res;
endmodule
`default_nettype wire

>>> sim/tb_qualified_provider_table.sv
// ---------------------------------------------------------------------------
// tb_qualified_provider_table
// self-checking bench for the provider table: a driver feeds items from a
// queue, a predictor works out each result, a monitor compares field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_qualified_provider_table;
  import qpt_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  qpt_stream_if #(.T(item_t)) in_ch ();
  qpt_stream_if #(.T(result_t)) out_ch ();

  qualified_provider_table u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [15:0] p_weight, p_floor;
  logic [4:0]  p_cap;
  int unsigned p_count;
  logic [31:0] t_key [16];
  logic [31:0] t_price [16];
  logic [16:0] t_risk [16];
  logic [22:0] t_lat [16];
  logic        t_acc [16];
  logic        t_ban [16];
  logic [15:0] t_succ [16];
  logic [15:0] t_fail [16];

  item_t   pending_items[$];
  result_t expected_results[$];
  int      send_idle_pct, recv_stall_pct;
  int      errors, results_seen;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [22:0] blend(logic [16:0] a, logic [22:0] old, logic [22:0] obs);
    logic [47:0] s;
    s = a * old + (17'd32768 - a) * obs + 48'd16384;
    return s[37:15];
  endfunction

  function automatic bit find_key(logic [31:0] key, output int idx);
    idx = 0;
    for (int i = 0; i < p_count; i++)
      if (t_key[i] == key) begin
        idx = i;
        return 1;
      end
    return 0;
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    int idx, best;
    bit found;
    logic [16:0] a, obs;
    logic [16:0] tot;
    logic signed [24:0] lat;
    r = '0;
    lat = it.latency;
    case (it.operation)
      OP_REGISTER: begin
        if (it.risk > ONE_Q15) r.status = ST_RISK;
        else if (p_count >= ((p_cap < 16) ? p_cap : 16)) r.status = ST_FULL;
        else if (find_key(it.provider_key, idx)) begin
          r.status = ST_DUPLICATE;
          r.slot_index = 4'(idx);
        end else begin
          idx = p_count;
          t_key[idx] = it.provider_key;
          t_price[idx] = it.price;
          t_risk[idx] = it.risk;
          t_lat[idx] = (lat < 0) ? 23'd0 : it.latency[22:0];
          t_acc[idx] = it.accepted;
          t_ban[idx] = 1'b0;
          t_succ[idx] = '0;
          t_fail[idx] = '0;
          p_count++;
          r.slot_index = 4'(idx);
        end
      end
      OP_BAN, OP_UNBAN, OP_REPORT: begin
        if (!find_key(it.provider_key, idx)) r.status = ST_NOT_FOUND;
        else begin
          r.slot_index = 4'(idx);
          if (it.operation == OP_BAN) begin
            t_ban[idx] = 1'b1;
            t_risk[idx] = ONE_Q15;
          end else if (it.operation == OP_UNBAN) begin
            t_ban[idx] = 1'b0;
          end else begin
            a = (p_weight > ONE_Q15) ? ONE_Q15 : p_weight;
            obs = (it.risk > ONE_Q15) ? ONE_Q15 : it.risk;
            t_risk[idx] = 17'(blend(a, t_risk[idx], obs));
            if (t_risk[idx] > ONE_Q15) t_risk[idx] = ONE_Q15;
            if (lat >= 0) t_lat[idx] = blend(a, t_lat[idx], it.latency[22:0]);
            if (it.success) begin
              if (t_succ[idx] != CNT_MAX) t_succ[idx]++;
            end else begin
              if (t_fail[idx] != CNT_MAX) t_fail[idx]++;
            end
            tot = t_succ[idx] + t_fail[idx];
            if (!t_ban[idx] && tot >= MIN_OUTCOMES && t_risk[idx] >= p_floor &&
                t_fail[idx] > t_succ[idx]) begin
              t_ban[idx] = 1'b1;
              t_risk[idx] = ONE_Q15;
              r.auto_banned = 1'b1;
            end
          end
        end
      end
      OP_SELECT: begin
        found = 0;
        best = 0;
        for (int i = 0; i < p_count; i++) begin
          if (!t_acc[i] || t_ban[i]) continue;
          if (t_price[i] > it.price || t_risk[i] > it.risk) continue;
          if ($signed({2'b0, t_lat[i]}) > lat) continue;
          if (!found) begin
            found = 1;
            best = i;
          end else if (t_price[i] < t_price[best]) best = i;
          else if (t_price[i] == t_price[best]) begin
            if (t_risk[i] < t_risk[best]) best = i;
            else if (t_risk[i] == t_risk[best] && t_lat[i] < t_lat[best]) best = i;
          end
        end
        if (!found) r.status = ST_NONE;
        else begin
          r.slot_index = 4'(best);
          r.chosen_key = t_key[best];
          r.chosen_price = t_price[best];
          r.chosen_risk = t_risk[best][15:0];
          r.chosen_latency = t_lat[best];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_results.push_back(predict_result(in_ch.payload));
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.payload <= pending_items.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_ch.payload);
          errors++;
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (e.status !== out_ch.payload.status ||
              e.slot_index !== out_ch.payload.slot_index ||
              e.chosen_key !== out_ch.payload.chosen_key ||
              e.chosen_price !== out_ch.payload.chosen_price ||
              e.chosen_risk !== out_ch.payload.chosen_risk ||
              e.chosen_latency !== out_ch.payload.chosen_latency ||
              e.auto_banned !== out_ch.payload.auto_banned) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_ch.payload);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WEIGHT: p_weight = val;
      CFG_FLOOR:  p_floor = val;
      default:    p_cap = val[4:0];
    endcase
  endtask

  function automatic item_t mk(op_t op, logic [31:0] key, logic [31:0] price,
                               logic [15:0] risk, logic [23:0] lat, bit acc, bit succ);
    item_t it;
    it.operation = op;
    it.provider_key = key;
    it.price = price;
    it.risk = risk;
    it.latency = lat;
    it.accepted = acc;
    it.success = succ;
    return it;
  endfunction

  function automatic logic [31:0] pick_key(logic [31:0] pool[$]);
    if (pool.size() != 0 && $urandom_range(9) < 8) return pool[$urandom_range(pool.size() - 1)];
    return $urandom_range(3) == 0 ? $urandom() : 32'h100 + $urandom_range(40);
  endfunction

  // random phase: a random mix of every operation
  task automatic random_phase(int n);
    logic [31:0] keys[$];
    item_t it;
    op_t op;
    int c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(99);
      if (c < 20) op = OP_REGISTER;
      else if (c < 27) op = OP_BAN;
      else if (c < 35) op = OP_UNBAN;
      else if (c < 60) op = OP_SELECT;
      else op = OP_REPORT;
      it = mk(op, pick_key(keys), $urandom_range(1000), $urandom_range(32768),
              $urandom_range(2000), $urandom_range(1), $urandom_range(3) == 0);
      if ($urandom_range(15) == 0) it.price = $urandom();
      if ($urandom_range(15) == 0) it.risk = $urandom();
      if ($urandom_range(15) == 0) it.latency = $urandom();
      if (op == OP_SELECT && $urandom_range(7) == 0) it.price = 32'hffffffff;
      if ($urandom_range(40) == 0) it.operation = 3'd5 + $urandom_range(2);
      if (op == OP_REGISTER) keys.push_back(it.provider_key);
      pending_items.push_back(it);
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    errors = 0;
    results_seen = 0;
    p_weight = 16'd26214;
    p_floor = 16'd22938;
    p_cap = 5'd16;
    p_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes and every status but full
    pending_items.push_back(mk(OP_SELECT, 0, 32'hffffffff, 16'hffff, 24'h7fffff, 1, 0));
    pending_items.push_back(mk(OP_BAN, 32'h5, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_REGISTER, 32'h1, 10, 16'd32769, 0, 1, 0));
    pending_items.push_back(mk(OP_REGISTER, 32'hffffffff, 32'hffffffff, 16'd32768,
                               24'h7fffff, 1, 1));
    pending_items.push_back(mk(OP_REGISTER, 32'h0, 0, 0, 24'h800000, 1, 0));
    pending_items.push_back(mk(OP_REGISTER, 32'h0, 5, 0, 0, 1, 0));
    pending_items.push_back(mk(OP_REGISTER, 32'h7, 0, 0, 24'd3, 1, 0));
    pending_items.push_back(mk(OP_REGISTER, 32'h8, 0, 0, 24'd3, 0, 0));
    pending_items.push_back(mk(OP_SELECT, 0, 32'hffffffff, 16'hffff, 24'h7fffff, 0, 0));
    pending_items.push_back(mk(OP_SELECT, 0, 0, 0, 24'hffffff, 0, 0));
    for (int i = 0; i < 5; i++)
      pending_items.push_back(mk(OP_REPORT, 32'h0, 0, 16'hffff, 24'h7fffff, 0, 0));
    pending_items.push_back(mk(OP_REPORT, 32'h7, 0, 0, 24'hffffff, 0, 1));
    pending_items.push_back(mk(OP_SELECT, 0, 32'hffffffff, 16'hffff, 24'h7fffff, 0, 0));
    pending_items.push_back(mk(OP_UNBAN, 32'h0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_BAN, 32'h7, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_SELECT, 0, 32'hffffffff, 16'hffff, 24'h7fffff, 0, 0));
    pending_items.push_back(mk(op_t'(3'd7), 32'hffffffff, 1, 1, 1, 1, 1));
    pending_items.push_back(mk(op_t'(3'd5), 0, 0, 0, 0, 0, 0));
    wait_drained();

    // sender holds off until everything is back, then a five-slot cap, zero weight and floor
    write_reg(CFG_SLOTS, 16'd5);
    write_reg(CFG_WEIGHT, 16'd0);
    write_reg(CFG_FLOOR, 16'd0);
    pending_items.push_back(mk(OP_REGISTER, 32'h20, 1, 0, 0, 1, 0));
    pending_items.push_back(mk(OP_REGISTER, 32'h21, 1, 0, 0, 1, 0));
    pending_items.push_back(mk(OP_REGISTER, 32'h22, 1, 0, 0, 1, 0));
    for (int i = 0; i < 4; i++)
      pending_items.push_back(mk(OP_REPORT, 32'h20, 0, 0, 24'd9, 0, 0));
    wait_drained();
    write_reg(CFG_SLOTS, 16'd0);
    write_reg(CFG_WEIGHT, 16'hffff);
    write_reg(CFG_FLOOR, 16'hffff);
    pending_items.push_back(mk(OP_REGISTER, 32'h30, 1, 0, 0, 1, 0));
    for (int i = 0; i < 5; i++)
      pending_items.push_back(mk(OP_REPORT, 32'h21, 0, 16'hffff, 24'd100, 0, 0));
    wait_drained();

    // random phases, fresh table each time is impossible so vary settings
    write_reg(CFG_SLOTS, 16'd31);
    write_reg(CFG_WEIGHT, 16'd32768);
    write_reg(CFG_FLOOR, 16'd1);
    send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(120);
    write_reg(CFG_WEIGHT, 16'd16384);
    write_reg(CFG_FLOOR, 16'd32768);
    send_idle_pct = 60; recv_stall_pct = 0;  random_phase(120);
    write_reg(CFG_WEIGHT, 16'd26214);
    write_reg(CFG_FLOOR, 16'd22938);
    write_reg(CFG_SLOTS, 16'd16);
    send_idle_pct = 0;  recv_stall_pct = 60; random_phase(130);
    write_reg(CFG_WEIGHT, 16'($urandom_range(32768)));
    write_reg(CFG_FLOOR, 16'($urandom_range(32768)));
    send_idle_pct = 30; recv_stall_pct = 30; random_phase(130);

    $display("covered register, ban, unban, report, select and unknown codes, %0d results",
             results_seen);
    $display("settings swept across capacity, weight and ban floor extremes with idling");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_qualified_provider_table OK");
    end else begin
      $display("tb_qualified_provider_table NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_qualified_provider_table NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/qpt_pkg.sv
rtl/qpt_if.sv
rtl/qpt_ctrl.sv
rtl/qpt_dpath.sv
rtl/qualified_provider_table.sv
sim/tb_qualified_provider_table.sv
